// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the log record deframer.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ldc_pkg.sv
// Package for the log record deframer: types, codes, constants and the CRC-32 step.
// No dependencies; imported by every module of the block.
package ldc_pkg;

    // Default width of the held key and value lengths.
    localparam int LENGTH_BITS_DEFAULT = 32;

    // Result queue between the parser and the output stage.
    localparam int QUEUE_DEPTH = 2;

    // Configuration port layout.
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_PUT_TYPE    = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_DELETE_TYPE = 1'b1;
    localparam logic [7:0] PUT_TYPE_RESET    = 8'h00;
    localparam logic [7:0] DELETE_TYPE_RESET = 8'h01;

    // Reflected CRC-32.
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Output stream widths.
    localparam int M_TDATA_W = 112;
    localparam int M_TUSER_W = 2;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_TYPE,
        PH_KEYLEN,
        PH_KEY,
        PH_VALLEN,
        PH_VAL,
        PH_CRC
    } phase_t;

    // Kind of a result transaction.
    typedef enum logic [1:0] {
        KIND_KEY,
        KIND_VALUE,
        KIND_VERDICT,
        KIND_SUMMARY
    } kind_t;

    // Record verdict or summary status.
    typedef enum logic [1:0] {
        ST_ACCEPTED,
        ST_CRC_MISMATCH,
        ST_BAD_TYPE,
        ST_TRUNCATED
    } status_t;

    // One result item as it travels through the queue.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        status_t     status;
        logic        is_delete;
        logic [31:0] key_length;
        logic [31:0] value_length;
        logic [31:0] accepted_count;
    } result_t;

    // Parser status seen by the top level.
    typedef struct packed {
        logic   halted;
        phase_t phase;
    } front_status_t;

    // One byte step of the reflected CRC-32, bit by bit.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'h000000, data};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/ldc_queue.sv
// Short result queue between the parser and the output stage.
// Depends on ldc_pkg for the result type and the queue depth.
module ldc_queue
    import ldc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output logic    full,
    output logic    empty,
    output result_t head,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    result_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/ldc_front.sv
// Record parser: walks the record fields, runs the CRC-32 and produces results.
// Depends on ldc_pkg for phases, result codes and the CRC step function.
module ldc_front
    import ldc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    input  logic [7:0]    put_code,
    input  logic [7:0]    delete_code,
    output logic          res_valid,
    output result_t       res,
    output front_status_t status
);

    phase_t                 phase_reg, phase_next;
    logic [1:0]             index_reg, index_next;
    logic [7:0]             type_reg, type_next;
    logic [LENGTH_BITS-1:0] key_len_reg, key_len_next;
    logic [LENGTH_BITS-1:0] val_len_reg, val_len_next;
    logic [LENGTH_BITS-1:0] remain_reg, remain_next;
    logic [31:0]            crc_reg, crc_next;
    logic [23:0]            stored_reg, stored_next;
    logic                   halted_reg, halted_next;
    logic [31:0]            count_reg, count_next;

    logic [31:0] crc_in;
    logic [31:0] crc_upd;
    logic [31:0] byte_shifted;
    logic [31:0] key_merged;
    logic [31:0] val_merged;
    logic [31:0] count_inc;
    logic        crc_match;

    assign status.halted = halted_reg;
    assign status.phase  = phase_reg;

    // A record's CRC starts from all ones at its type byte.
    assign crc_in       = (phase_reg == PH_TYPE) ? CRC_INIT : crc_reg;
    assign crc_upd      = crc32_byte(crc_in, in_byte);
    assign byte_shifted = {24'h000000, in_byte} << {index_reg, 3'b000};
    assign key_merged   = 32'(key_len_reg) | byte_shifted;
    assign val_merged   = 32'(val_len_reg) | byte_shifted;
    assign count_inc    = (count_reg == 32'hFFFFFFFF) ? count_reg : count_reg + 32'd1;
    assign crc_match    = ((crc_reg ^ CRC_INIT) == {in_byte, stored_reg});

    // Next state and result for one accepted transaction.
    always_comb
    begin
        phase_next   = phase_reg;
        index_next   = index_reg;
        type_next    = type_reg;
        key_len_next = key_len_reg;
        val_len_next = val_len_reg;
        remain_next  = remain_reg;
        crc_next     = crc_reg;
        stored_next  = stored_reg;
        halted_next  = halted_reg;
        count_next   = count_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (in_fire)
        begin
            if (in_last)
            begin
                // End of log: report and return to the start state.
                res_valid          = 1'b1;
                res.kind           = KIND_SUMMARY;
                res.status         = (!halted_reg && phase_reg != PH_TYPE) ?
                                     ST_TRUNCATED : ST_ACCEPTED;
                res.accepted_count = count_reg;
                phase_next   = PH_TYPE;
                index_next   = '0;
                type_next    = '0;
                key_len_next = '0;
                val_len_next = '0;
                remain_next  = '0;
                crc_next     = CRC_INIT;
                stored_next  = '0;
                halted_next  = 1'b0;
                count_next   = '0;
            end
            else if (!halted_reg)
            begin
                unique case (phase_reg)
                    PH_TYPE:
                    begin
                        type_next    = in_byte;
                        crc_next     = crc_upd;
                        key_len_next = '0;
                        val_len_next = '0;
                        stored_next  = '0;
                        index_next   = '0;
                        phase_next   = PH_KEYLEN;
                    end
                    PH_KEYLEN:
                    begin
                        crc_next     = crc_upd;
                        key_len_next = key_merged[LENGTH_BITS-1:0];
                        index_next   = index_reg + 2'd1;
                        if (index_reg == 2'd3)
                        begin
                            remain_next = key_merged[LENGTH_BITS-1:0];
                            phase_next  = (key_merged[LENGTH_BITS-1:0] != '0) ?
                                          PH_KEY : PH_VALLEN;
                        end
                    end
                    PH_VALLEN:
                    begin
                        crc_next     = crc_upd;
                        val_len_next = val_merged[LENGTH_BITS-1:0];
                        index_next   = index_reg + 2'd1;
                        if (index_reg == 2'd3)
                        begin
                            remain_next = val_merged[LENGTH_BITS-1:0];
                            phase_next  = (val_merged[LENGTH_BITS-1:0] != '0) ?
                                          PH_VAL : PH_CRC;
                        end
                    end
                    PH_KEY, PH_VAL:
                    begin
                        // Payload byte passes straight through.
                        crc_next     = crc_upd;
                        remain_next  = remain_reg - LENGTH_BITS'(1);
                        res_valid    = 1'b1;
                        res.kind     = (phase_reg == PH_KEY) ? KIND_KEY : KIND_VALUE;
                        res.out_byte = in_byte;
                        if (remain_reg == LENGTH_BITS'(1))
                        begin
                            index_next = '0;
                            phase_next = (phase_reg == PH_KEY) ? PH_VALLEN : PH_CRC;
                        end
                    end
                    PH_CRC:
                    begin
                        index_next = index_reg + 2'd1;
                        unique case (index_reg)
                            2'd0: stored_next[7:0]   = in_byte;
                            2'd1: stored_next[15:8]  = in_byte;
                            2'd2: stored_next[23:16] = in_byte;
                            2'd3:
                            begin
                                // Verdict: CRC first, then the type code.
                                phase_next         = PH_TYPE;
                                res_valid          = 1'b1;
                                res.kind           = KIND_VERDICT;
                                res.key_length     = 32'(key_len_reg);
                                res.value_length   = 32'(val_len_reg);
                                res.accepted_count = count_reg;
                                if (!crc_match)
                                begin
                                    res.status  = ST_CRC_MISMATCH;
                                    halted_next = 1'b1;
                                end
                                else if (type_reg != put_code && type_reg != delete_code)
                                begin
                                    res.status  = ST_BAD_TYPE;
                                    halted_next = 1'b1;
                                end
                                else
                                begin
                                    res.status         = ST_ACCEPTED;
                                    res.is_delete      = (type_reg != put_code);
                                    res.accepted_count = count_inc;
                                    count_next         = count_inc;
                                end
                            end
                        endcase
                    end
                    default:
                    begin
                        phase_next = PH_TYPE;
                        index_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TYPE;
            index_reg   <= '0;
            type_reg    <= '0;
            key_len_reg <= '0;
            val_len_reg <= '0;
            remain_reg  <= '0;
            crc_reg     <= CRC_INIT;
            stored_reg  <= '0;
            halted_reg  <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            index_reg   <= index_next;
            type_reg    <= type_next;
            key_len_reg <= key_len_next;
            val_len_reg <= val_len_next;
            remain_reg  <= remain_next;
            crc_reg     <= crc_next;
            stored_reg  <= stored_next;
            halted_reg  <= halted_next;
            count_reg   <= count_next;
        end
    end

endmodule

// File: rtl/ldc_back.sv
// Output stage: drains the result queue into the master stream register.
// Depends on ldc_pkg for the result type and stream widths.
module ldc_back
    import ldc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  result_t              q_head,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    logic    valid_reg, valid_next;
    result_t out_reg;

    // Load a new result when the register is free or being taken.
    assign q_pop      = !q_empty && (!valid_reg || m_tready);
    assign valid_next = q_pop ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_reg <= q_head;
        end
    end

    // Pack the result fields, lowest field first, zero padded to whole bytes.
    assign m_tvalid = valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {5'b00000,
                       out_reg.accepted_count,
                       out_reg.value_length,
                       out_reg.key_length,
                       out_reg.is_delete,
                       out_reg.status,
                       out_reg.out_byte};

endmodule

// File: rtl/log_record_deframer_crc32_top.sv
// Top level of the log record deframer with CRC-32 check and its register port.
// Depends on ldc_pkg, ldc_front, ldc_queue, ldc_back and assert_macros.svh.
//
// Usage:
//   The slave stream takes one log byte per transaction in s_tdata; s_tlast
//   marks the end-of-log item, whose byte is ignored. The master stream gives
//   one result transaction per key byte, value byte, record verdict and
//   end-of-log summary; m_tuser holds the result kind.
//   Throughput is one byte per cycle while the queue has room: the parser
//   does a byte-wide CRC-32 update and a length counter step per cycle,
//   and a two-entry result queue decouples it from the output register.
//   A result enters the result queue when the byte that caused it is
//   accepted, and moves from the queue into the output register once that
//   register is free or being taken by the receiver.
//   Reset clears the parser to the type-byte phase, empties the queue and
//   loads the register reset codes (put 0, delete 1).
//   When the receiver stalls, the output register holds and the queue fills;
//   s_tready falls once the queue is full and rises again as soon as the
//   output register takes an entry from it.
//   Write the registers over the APB port only while the stream is idle
//   (not enforced): put_type_code at byte address 0, delete_type_code at 4.
`include "assert_macros.svh"

module log_record_deframer_crc32_top
    import ldc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Slave stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] byte_value
    input  logic                 s_tlast,
    // Master stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] out_byte, [9:8] record_status, [10] is_delete, [42:11] key_length,
    // [74:43] value_length, [106:75] accepted_count, [111:107] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,   // [1:0] out_kind
    // APB configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [7:0]           put_code_reg, put_code_next;
    logic [7:0]           del_code_reg, del_code_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    logic          in_fire;
    logic          res_valid;
    result_t       res;
    front_status_t front_st;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    result_t       q_head;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

    // Configuration registers.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        put_code_next = put_code_reg;
        del_code_next = del_code_reg;
        prdata        = '0;
        unique case (reg_idx)
            REG_PUT_TYPE:
            begin
                prdata = {24'h000000, put_code_reg};
                if (cfg_write)
                begin
                    put_code_next = pwdata[7:0];
                end
            end
            REG_DELETE_TYPE:
            begin
                prdata = {24'h000000, del_code_reg};
                if (cfg_write)
                begin
                    del_code_next = pwdata[7:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            put_code_reg <= PUT_TYPE_RESET;
            del_code_reg <= DELETE_TYPE_RESET;
        end
        else
        begin
            put_code_reg <= put_code_next;
            del_code_reg <= del_code_next;
        end
    end

    // Every byte may cause one result, so accept only while the queue has room.
    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    ldc_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .put_code    (put_code_reg),
        .delete_code (del_code_reg),
        .res_valid   (res_valid),
        .res         (res),
        .status      (front_st)
    );

    ldc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head),
        .count     (q_count)
    );

    ldc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Checks on the parser and the queue.
    `ASSERT_ALWAYS(a_queue_bound, clk, rst_n, q_count <= ($bits(q_count))'(QUEUE_DEPTH), "result queue overfilled")
    `ASSERT_IMPLIES(a_halted_silent, clk, rst_n, in_fire && front_st.halted && !s_tlast, !res_valid, "halted parser produced a result")
    `ASSERT_IMPLIES(a_accept_counts, clk, rst_n, res_valid && res.kind == KIND_VERDICT && res.status == ST_ACCEPTED, res.accepted_count != 32'd0, "accepted record not counted")
    `ASSERT_NEXT(a_end_restarts, clk, rst_n, in_fire && s_tlast, front_st.phase == PH_TYPE && !front_st.halted, "end of log did not restart the parser")

endmodule

// File: test/log_record_deframer_crc32_top_tb.sv
// Self-checking testbench for the log record deframer with CRC-32 check.
// Depends on ldc_pkg and log_record_deframer_crc32_top; streams whole, broken
// and noisy records under random idling and compares every result transaction.
`timescale 1ns / 1ps

module log_record_deframer_crc32_top_tb;
    import ldc_pkg::*;

    // One log byte transaction waiting to be sent.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } log_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [7:0] byte_value
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    // [7:0] out_byte, [9:8] record_status, [10] is_delete, [42:11] key_length,
    // [74:43] value_length, [106:75] accepted_count, [111:107] zero
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;   // [1:0] out_kind
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // Stimulus and expected results.
    log_item_t   pending_bytes[$];
    result_t     expected_results[$];
    int          items_queued;
    int          error_count;
    int          send_gap_max;
    int          recv_stall_max;
    int          send_wait;
    int          recv_wait;
    bit          byte_taken;
    bit          result_taken;

    // Local copy of the registers.
    logic [7:0]  put_code;
    logic [7:0]  del_code;

    // Local copy of the parser state.
    phase_t      ph;
    logic [1:0]  byte_idx;
    logic [7:0]  rec_type;
    logic [31:0] key_len;
    logic [31:0] val_len;
    logic [31:0] remaining;
    logic [31:0] crc_acc;
    logic [31:0] crc_rx;
    logic        stopped;
    logic [31:0] accept_total;

    log_record_deframer_crc32_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Reflected CRC-32 update over one byte, shifting out one bit at a time.
    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] acc;
        acc = c ^ {24'h000000, d};
        for (int i = 0; i < 8; i++)
        begin
            acc = {1'b0, acc[31:1]} ^ (acc[0] ? CRC_POLY : 32'h00000000);
        end
        return acc;
    endfunction

    // Return the parser copy to its post-reset state.
    task automatic clear_parser();
        ph           = PH_TYPE;
        byte_idx     = 2'd0;
        rec_type     = 8'h00;
        key_len      = 32'h0;
        val_len      = 32'h0;
        remaining    = 32'h0;
        crc_acc      = CRC_INIT;
        crc_rx       = 32'h0;
        stopped      = 1'b0;
        accept_total = 32'h0;
    endtask

    // Advance the parser copy by one accepted transaction and queue its result.
    task automatic step_parser(input logic [7:0] b, input logic eol);
        result_t r;
        r = '0;
        if (eol)
        begin
            r.kind           = KIND_SUMMARY;
            r.status         = (!stopped && ph != PH_TYPE) ? ST_TRUNCATED : ST_ACCEPTED;
            r.accepted_count = accept_total;
            expected_results.insert(expected_results.size(), r);
            clear_parser();
        end
        else if (!stopped)
        begin
            case (ph)
                PH_TYPE:
                begin
                    rec_type = b;
                    crc_acc  = crc_step(CRC_INIT, b);
                    key_len  = 32'h0;
                    val_len  = 32'h0;
                    crc_rx   = 32'h0;
                    byte_idx = 2'd0;
                    ph       = PH_KEYLEN;
                end
                PH_KEYLEN, PH_VALLEN:
                begin
                    crc_acc = crc_step(crc_acc, b);
                    if (ph == PH_KEYLEN)
                        key_len[8*byte_idx +: 8] = b;
                    else
                        val_len[8*byte_idx +: 8] = b;
                    if (byte_idx != 2'd3)
                        byte_idx = byte_idx + 2'd1;
                    else
                    begin
                        byte_idx = 2'd0;
                        if (ph == PH_KEYLEN)
                        begin
                            remaining = key_len;
                            ph = (key_len != 0) ? PH_KEY : PH_VALLEN;
                        end
                        else
                        begin
                            remaining = val_len;
                            ph = (val_len != 0) ? PH_VAL : PH_CRC;
                        end
                    end
                end
                PH_KEY, PH_VAL:
                begin
                    crc_acc    = crc_step(crc_acc, b);
                    remaining  = remaining - 32'd1;
                    r.kind     = (ph == PH_KEY) ? KIND_KEY : KIND_VALUE;
                    r.out_byte = b;
                    expected_results.insert(expected_results.size(), r);
                    if (remaining == 0)
                    begin
                        byte_idx = 2'd0;
                        ph = (ph == PH_KEY) ? PH_VALLEN : PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    crc_rx[8*byte_idx +: 8] = b;
                    if (byte_idx != 2'd3)
                        byte_idx = byte_idx + 2'd1;
                    else
                    begin
                        byte_idx = 2'd0;
                        ph       = PH_TYPE;
                        r.kind   = KIND_VERDICT;
                        // The CRC verdict takes priority over the type check.
                        if (~crc_acc != crc_rx)
                        begin
                            r.status = ST_CRC_MISMATCH;
                            stopped  = 1'b1;
                        end
                        else if (rec_type != put_code && rec_type != del_code)
                        begin
                            r.status = ST_BAD_TYPE;
                            stopped  = 1'b1;
                        end
                        else
                        begin
                            r.status    = ST_ACCEPTED;
                            r.is_delete = (rec_type != put_code);
                            if (accept_total != 32'hFFFFFFFF)
                                accept_total = accept_total + 32'd1;
                        end
                        r.key_length     = key_len;
                        r.value_length   = val_len;
                        r.accepted_count = accept_total;
                        expected_results.insert(expected_results.size(), r);
                    end
                end
                default:
                begin
                    ph       = PH_TYPE;
                    byte_idx = 2'd0;
                end
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < 100)
            $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        log_item_t item;
        item.data = b;
        item.last = last;
        pending_bytes.insert(pending_bytes.size(), item);
        items_queued++;
    endtask

    task automatic push_eol();
        push_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Build one record with random payload; stop_at limits how many bytes go out.
    task automatic queue_record(input logic [7:0] typ, input logic [31:0] klen,
                                input logic [31:0] vlen, input bit bad_crc,
                                input int unsigned stop_at);
        logic [7:0]  rec[$];
        logic [31:0] crc;
        rec.insert(rec.size(), typ);
        for (int i = 0; i < 4; i++)
            rec.insert(rec.size(), klen[8*i +: 8]);
        for (int unsigned i = 0; i < klen && rec.size() < stop_at; i++)
            rec.insert(rec.size(), 8'($urandom_range(0, 255)));
        for (int i = 0; i < 4; i++)
            rec.insert(rec.size(), vlen[8*i +: 8]);
        for (int unsigned i = 0; i < vlen && rec.size() < stop_at; i++)
            rec.insert(rec.size(), 8'($urandom_range(0, 255)));
        crc = CRC_INIT;
        foreach (rec[i])
            crc = crc_step(crc, rec[i]);
        crc = ~crc;
        if (bad_crc)
            crc = crc ^ (32'h1 << $urandom_range(0, 31));
        for (int i = 0; i < 4; i++)
            rec.insert(rec.size(), crc[8*i +: 8]);
        for (int unsigned i = 0; i < rec.size() && i < stop_at; i++)
            push_byte(rec[i], 1'b0);
    endtask

    // Wait until every byte is sent and every result has come, then let the pipe settle.
    task automatic wait_drained();
        int guard;
        guard = 0;
        do
        begin
            @(negedge clk);
            guard++;
        end
        while (!(pending_bytes.size() == 0 && !s_tvalid && expected_results.size() == 0)
               && guard < 200000);
        repeat (8) @(negedge clk);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h000000, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_PUT_TYPE)
            put_code = value;
        else
            del_code = value;
    endtask

    // Random mix of records: mostly well formed, some broken, cut off or noise.
    task automatic run_random(input int target);
        int          start;
        int          sel;
        int          pick;
        logic [7:0]  typ;
        logic [31:0] kl;
        logic [31:0] vl;
        start = items_queued;
        while (items_queued - start < target)
        begin
            sel  = $urandom_range(0, 99);
            pick = $urandom_range(0, 9);
            typ  = (pick < 4) ? put_code : (pick < 8) ? del_code : 8'($urandom_range(0, 255));
            kl   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            vl   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 19) == 0)
                kl = $urandom_range(20, 40);
            if (sel < 70)
            begin
                queue_record(typ, kl, vl, 1'b0, 32'hFFFFFFFF);
                if ($urandom_range(0, 9) == 0)
                    push_eol();
            end
            else if (sel < 80)
            begin
                queue_record(typ, kl, vl, 1'b1, 32'hFFFFFFFF);
                if ($urandom_range(0, 2) == 0)
                    push_eol();
            end
            else if (sel < 88)
            begin
                queue_record(typ, kl, vl, 1'b0, $urandom_range(1, 12 + kl + vl));
                push_eol();
            end
            else if (sel < 93)
            begin
                repeat ($urandom_range(1, 12))
                    push_byte(8'($urandom_range(0, 255)), 1'b0);
                push_eol();
            end
            else if (sel < 96)
            begin
                // Large declared length, cut off well before the payload ends.
                queue_record(typ, $urandom, vl, 1'b0, $urandom_range(5, 9));
                push_eol();
            end
            else
                push_eol();
            if ($urandom_range(0, 29) == 0)
                wait_drained();
        end
    endtask

    // Capture accepted input transactions and predict their results.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            byte_taken = 1'b1;
            step_parser(s_tdata, s_tlast);
        end
    end

    // Driver: presents queued bytes with a random gap before each one.
    always @(negedge clk)
    begin
        log_item_t item;
        if (rst_n && (!s_tvalid || byte_taken))
        begin
            byte_taken = 1'b0;
            if (send_wait > 0)
            begin
                send_wait--;
                s_tvalid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                item = pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= item.data;
                s_tlast  <= item.last;
                send_wait = $urandom_range(0, send_gap_max);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: stalls a random number of cycles after each result transaction.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
            begin
                result_taken = 1'b0;
                recv_wait = $urandom_range(0, recv_stall_max);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: compares each result transaction with the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            result_taken = 1'b1;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result kind", 32'(m_tuser), 32'h0);
            else
            begin
                want = expected_results.pop_front();
                if (m_tuser != want.kind)
                    report_mismatch("out_kind", 32'(m_tuser), 32'(want.kind));
                if (m_tdata[7:0] != want.out_byte)
                    report_mismatch("out_byte", 32'(m_tdata[7:0]), 32'(want.out_byte));
                if (m_tdata[9:8] != want.status)
                    report_mismatch("record_status", 32'(m_tdata[9:8]), 32'(want.status));
                if (m_tdata[10] != want.is_delete)
                    report_mismatch("is_delete", 32'(m_tdata[10]), 32'(want.is_delete));
                if (m_tdata[42:11] != want.key_length)
                    report_mismatch("key_length", m_tdata[42:11], want.key_length);
                if (m_tdata[74:43] != want.value_length)
                    report_mismatch("value_length", m_tdata[74:43], want.value_length);
                if (m_tdata[106:75] != want.accepted_count)
                    report_mismatch("accepted_count", m_tdata[106:75], want.accepted_count);
            end
        end
    end

    // Run limit.
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus sequence: reset, directed records, then random phases.
    initial
    begin
        logic [7:0] put_set[7];
        logic [7:0] del_set[7];
        int         gap_set[7];
        int         stall_set[7];
        put_set   = '{8'h00, 8'hFF, 8'h5A, 8'h00, 8'hFF, 8'h00, 8'h00};
        del_set   = '{8'h01, 8'h00, 8'h5A, 8'hFF, 8'hFF, 8'h00, 8'h01};
        gap_set   = '{8, 0, 8, 0, 8, 8, 3};
        stall_set = '{8, 0, 8, 8, 0, 8, 3};
        put_set[5] = 8'($urandom_range(0, 255));
        del_set[5] = 8'($urandom_range(0, 255));

        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = 32'h0;
        items_queued   = 0;
        error_count    = 0;
        send_wait      = 0;
        recv_wait      = 0;
        byte_taken     = 1'b0;
        result_taken   = 1'b0;
        send_gap_max   = gap_set[0];
        recv_stall_max = stall_set[0];
        put_code       = PUT_TYPE_RESET;
        del_code       = DELETE_TYPE_RESET;
        clear_parser();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part with the reset codes.
        push_eol();
        queue_record(PUT_TYPE_RESET, 32'd1, 32'd0, 1'b0, 32'hFFFFFFFF);
        queue_record(DELETE_TYPE_RESET, 32'd0, 32'd2, 1'b0, 32'hFFFFFFFF);
        push_eol();
        // Record cut off inside the key length.
        queue_record(PUT_TYPE_RESET, 32'h0000_0300, 32'd0, 1'b0, 4);
        push_eol();
        // CRC mismatch; following bytes are ignored until end of log.
        queue_record(DELETE_TYPE_RESET, 32'd0, 32'd0, 1'b1, 32'hFFFFFFFF);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_eol();
        // Good CRC with a type that matches neither code.
        queue_record(8'h77, 32'd0, 32'd0, 1'b0, 32'hFFFFFFFF);
        push_eol();
        wait_drained();

        for (int p = 0; p < 7; p++)
        begin
            if (p > 0)
            begin
                wait_drained();
                apb_write(REG_PUT_TYPE, put_set[p]);
                apb_write(REG_DELETE_TYPE, del_set[p]);
            end
            send_gap_max   = gap_set[p];
            recv_stall_max = stall_set[p];
            run_random(135);
        end
        push_eol();

        wait_drained();
        if (expected_results.size() != 0 || pending_bytes.size() != 0)
            report_mismatch("results left over", 32'(expected_results.size()), 32'h0);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/ldc_pkg.sv
rtl/ldc_queue.sv
rtl/ldc_front.sv
rtl/ldc_back.sv
rtl/log_record_deframer_crc32_top.sv
test/log_record_deframer_crc32_top_tb.sv
